/* src/siocfg_pkg.sv */
package siocfg_pkg;

  localparam int NUM_REGS_DEF = 42;

  localparam logic [7:0] KEY_ENTER     = 8'h55;
  localparam logic [7:0] KEY_EXIT      = 8'hAA;
  localparam logic [7:0] PROTECT_LIMIT = 8'h18;
  localparam logic [7:0] PROTECTED_VAL = 8'hFF;

  localparam logic [7:0] REG_CFG0    = 8'h00;
  localparam logic [7:0] REG_CFG1    = 8'h01;
  localparam logic [7:0] REG_CFG2    = 8'h02;
  localparam logic [7:0] REG_FLOPPY  = 8'h20;
  localparam logic [7:0] REG_IDE     = 8'h21;
  localparam logic [7:0] REG_IDE_ALT = 8'h22;
  localparam logic [7:0] REG_PRINTER = 8'h23;
  localparam logic [7:0] REG_SER_A   = 8'h24;
  localparam logic [7:0] REG_SER_B   = 8'h25;
  localparam logic [7:0] REG_RO_A    = 8'h26;
  localparam logic [7:0] REG_RO_B    = 8'h27;
  localparam logic [7:0] REG_IRQ     = 8'h28;
  localparam logic [7:0] REG_RO_C    = 8'h29;

  localparam logic [9:0] FLOPPY_PRI  = 10'h3F0;
  localparam logic [9:0] FLOPPY_SEC  = 10'h370;
  localparam logic [9:0] IDE_PRI     = 10'h1F0;
  localparam logic [9:0] IDE_SEC     = 10'h170;
  localparam logic [9:0] IDE_ALT_PRI = 10'h3F6;
  localparam logic [9:0] IDE_ALT_SEC = 10'h376;
  localparam logic [9:0] LPT_MONO    = 10'h3BC;
  localparam logic [9:0] LPT_PRI     = 10'h378;
  localparam logic [9:0] LPT_SEC     = 10'h278;
  localparam logic [9:0] COM_A_DEF   = 10'h3F8;
  localparam logic [9:0] COM_B_DEF   = 10'h2F8;

  function automatic logic serial_ok(input logic [6:0] f);
    logic ok;
    case (f)
      7'h7F, 7'h5F, 7'h67, 7'h7D, 7'h5D, 7'h44, 7'h47, 7'h5C, 7'h45: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Forces a base or IRQ register byte to one of its allowed encodings.
  function automatic logic [7:0] fix_word(input logic [7:0] addr, input logic [7:0] v);
    logic [7:0] nv;
    nv = v;
    case (addr)
      REG_FLOPPY: begin
        if (v[7:2] != FLOPPY_PRI[9:4] && v[7:2] != FLOPPY_SEC[9:4]) begin
          nv = {FLOPPY_PRI[9:4], v[1:0]};
        end
      end
      REG_IDE: begin
        if (v[7:2] != IDE_PRI[9:4] && v[7:2] != IDE_SEC[9:4]) begin
          nv = {IDE_PRI[9:4], v[1:0]};
        end
      end
      REG_IDE_ALT: begin
        if (v[7:2] != IDE_ALT_PRI[9:4] && v[7:2] != IDE_ALT_SEC[9:4]) begin
          nv = {IDE_ALT_PRI[9:4], v[1:0]};
        end
      end
      REG_PRINTER: begin
        if (v != LPT_MONO[9:2] && v != LPT_PRI[9:2] && v != LPT_SEC[9:2]) begin
          nv = LPT_PRI[9:2];
        end
      end
      REG_SER_A: begin
        if (!serial_ok(v[7:1])) begin
          nv = {COM_A_DEF[9:3], v[0]};
        end
      end
      REG_SER_B: begin
        if (!serial_ok(v[7:1])) begin
          nv = {COM_B_DEF[9:3], v[0]};
        end
      end
      REG_IRQ: begin
        if (v[3:0] == 4'h0) begin
          nv[3:0] = 4'h3;
        end
        if (v[7:4] == 4'h0) begin
          nv[7:4] = 4'h4;
        end
      end
      default: nv = v;
    endcase
    return nv;
  endfunction

  function automatic logic [7:0] reset_value(input logic [7:0] addr);
    logic [7:0] v;
    case (addr)
      8'h00: v = 8'h28;
      8'h01: v = 8'h9C;
      8'h02: v = 8'h88;
      8'h03: v = 8'h78;
      8'h06: v = 8'hFF;
      8'h0D: v = 8'h03;
      8'h0E: v = 8'h02;
      8'h1E: v = 8'h3C;
      8'h20: v = 8'hFC;
      8'h21: v = 8'h7C;
      8'h22: v = 8'hFD;
      8'h23: v = 8'hDE;
      8'h24: v = 8'hFE;
      8'h25: v = 8'hBE;
      8'h26: v = 8'h24;
      8'h27: v = 8'h67;
      8'h28: v = 8'h43;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

/* src/siocfg_ram.sv */
module siocfg_ram #(
  parameter int Width = 8,
  parameter int Depth = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/superio_config_register_port_core.sv */
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_stall  kind, port_select, write_data
// out      output     out_valid / out_stall read_data, pass_through, in_config, bases,
//                                          enable_mask, serial_irqs
//
// One bus access is accepted per cycle while the result is not stalled.
// The access sits in an input register while short logic updates the register file
// and fills the result register.
// The register file is a RAM with one valid bit per entry; an unwritten entry reads as
// its power-on value, so reset takes effect at once with no clearing pass.
// A stalled result holds, and one further access is still taken into the input register.
module superio_config_register_port_core #(
  parameter int NUM_REGS = siocfg_pkg::NUM_REGS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic       port_select,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       pass_through,
  output logic       in_config,
  output logic [9:0] floppy_base,
  output logic [9:0] ide_base,
  output logic [9:0] ide_alt_base,
  output logic [9:0] printer_base,
  output logic [9:0] serial_a_base,
  output logic [9:0] serial_b_base,
  output logic [4:0] enable_mask,
  output logic [7:0] serial_irqs
);
  import siocfg_pkg::*;

  localparam int AW = $clog2(NUM_REGS);
  localparam logic [7:0] NUM_REGS_B = 8'(NUM_REGS);

  logic          in_full;
  logic          kind_q;
  logic          sel_q;
  logic [7:0]    data_q;
  logic          go;

  logic [AW-1:0] index, index_next;
  logic          cfg_mode, cfg_mode_next;
  logic          pending, pending_next;
  logic          low_protect, low_protect_next;
  logic [NUM_REGS-1:0] valid;

  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;
  logic          bypass;
  logic [7:0]    bypass_data;
  logic [7:0]    index_b;
  logic [7:0]    word;
  logic [7:0]    rd_value;
  logic          pass;

  logic [7:0] r0, r1, r2, r20, r21, r22, r23, r24, r25, r28;
  logic [7:0] r0_next, r1_next, r2_next, r20_next, r21_next, r22_next;
  logic [7:0] r23_next, r24_next, r25_next, r28_next;

  assign go       = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign index_b  = 8'(index);

  siocfg_ram #(.Width(8), .Depth(NUM_REGS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (index),
    .wdata (ram_wdata),
    .raddr (index_next),
    .rdata (ram_q)
  );

  always_comb begin
    word = valid[index] ? (bypass ? bypass_data : ram_q) : reset_value(index_b);
  end

  always_comb begin
    index_next       = index;
    cfg_mode_next    = cfg_mode;
    pending_next     = pending;
    low_protect_next = low_protect;
    ram_we           = 1'b0;
    ram_wdata        = fix_word(index_b, data_q);
    rd_value         = 8'h00;
    pass             = 1'b0;
    if (go) begin
      if (kind_q) begin
        if (!sel_q) begin
          if (data_q == KEY_ENTER && !cfg_mode) begin
            if (pending) begin
              cfg_mode_next = 1'b1;
              pending_next  = 1'b0;
            end else begin
              pending_next = 1'b1;
            end
          end else if (cfg_mode) begin
            if (data_q < NUM_REGS_B) begin
              index_next = data_q[AW-1:0];
            end
            if (data_q == KEY_EXIT) begin
              cfg_mode_next = 1'b0;
            end
          end else begin
            pending_next = 1'b0;
          end
        end else if (cfg_mode && !(index_b < PROTECT_LIMIT && low_protect) &&
                     index_b != REG_RO_A && index_b != REG_RO_B &&
                     index_b != REG_RO_C) begin
          ram_we = 1'b1;
          if (index_b == REG_CFG1) begin
            low_protect_next = !data_q[3];
          end
        end
      end else begin
        if (!cfg_mode) begin
          pass = 1'b1;
        end else if (!sel_q) begin
          rd_value = index_b;
        end else if (index_b < PROTECT_LIMIT && low_protect) begin
          rd_value = PROTECTED_VAL;
        end else begin
          rd_value = word;
        end
      end
    end
  end

  always_comb begin
    r0_next  = (ram_we && index_b == REG_CFG0)    ? ram_wdata : r0;
    r1_next  = (ram_we && index_b == REG_CFG1)    ? ram_wdata : r1;
    r2_next  = (ram_we && index_b == REG_CFG2)    ? ram_wdata : r2;
    r20_next = (ram_we && index_b == REG_FLOPPY)  ? ram_wdata : r20;
    r21_next = (ram_we && index_b == REG_IDE)     ? ram_wdata : r21;
    r22_next = (ram_we && index_b == REG_IDE_ALT) ? ram_wdata : r22;
    r23_next = (ram_we && index_b == REG_PRINTER) ? ram_wdata : r23;
    r24_next = (ram_we && index_b == REG_SER_A)   ? ram_wdata : r24;
    r25_next = (ram_we && index_b == REG_SER_B)   ? ram_wdata : r25;
    r28_next = (ram_we && index_b == REG_IRQ)     ? ram_wdata : r28;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      out_valid   <= 1'b0;
      index       <= '0;
      cfg_mode    <= 1'b0;
      pending     <= 1'b0;
      low_protect <= 1'b0;
      valid       <= '0;
      bypass      <= 1'b0;
      r0          <= reset_value(REG_CFG0);
      r1          <= reset_value(REG_CFG1);
      r2          <= reset_value(REG_CFG2);
      r20         <= reset_value(REG_FLOPPY);
      r21         <= reset_value(REG_IDE);
      r22         <= reset_value(REG_IDE_ALT);
      r23         <= reset_value(REG_PRINTER);
      r24         <= reset_value(REG_SER_A);
      r25         <= reset_value(REG_SER_B);
      r28         <= reset_value(REG_IRQ);
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (go) begin
        in_full <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      index       <= index_next;
      cfg_mode    <= cfg_mode_next;
      pending     <= pending_next;
      low_protect <= low_protect_next;
      if (ram_we) begin
        valid[index] <= 1'b1;
      end
      bypass <= ram_we && (index == index_next);
      r0     <= r0_next;
      r1     <= r1_next;
      r2     <= r2_next;
      r20    <= r20_next;
      r21    <= r21_next;
      r22    <= r22_next;
      r23    <= r23_next;
      r24    <= r24_next;
      r25    <= r25_next;
      r28    <= r28_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q <= kind;
      sel_q  <= port_select;
      data_q <= write_data;
    end
    bypass_data <= ram_wdata;
    if (go) begin
      read_data     <= rd_value;
      pass_through  <= pass;
      in_config     <= cfg_mode_next;
      floppy_base   <= {r20_next[7:2], 4'h0};
      ide_base      <= {r21_next[7:2], 4'h0};
      ide_alt_base  <= {r22_next[7:2], 4'h6};
      printer_base  <= {r23_next, 2'b00};
      serial_a_base <= {r24_next[7:1], 3'b000};
      serial_b_base <= {r25_next[7:1], 3'b000};
      enable_mask   <= {r2_next[7], r2_next[3], r1_next[2],
                        r0_next[1:0] == 2'b10, r0_next[3]};
      serial_irqs   <= r28_next;
    end
  end
endmodule

/* src/siocfg_checker.sv */
module siocfg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       pass_through,
  input logic       in_config,
  input logic [9:0] floppy_base,
  input logic [9:0] ide_alt_base
);
  import siocfg_pkg::*;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result register could take a word.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(in_config))
    else $error("Stalled result word changed.");

  a_pass_through_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && pass_through |-> read_data == 8'h00 && !in_config)
    else $error("Pass-through word carries data or configuration mode.");

  a_floppy_base_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> floppy_base == FLOPPY_PRI || floppy_base == FLOPPY_SEC)
    else $error("Floppy base outside its allowed values.");

  a_ide_alt_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ide_alt_base == IDE_ALT_PRI || ide_alt_base == IDE_ALT_SEC)
    else $error("IDE alternate base outside its allowed values.");
endmodule

bind superio_config_register_port_core siocfg_checker u_siocfg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .read_data    (read_data),
  .pass_through (pass_through),
  .in_config    (in_config),
  .floppy_base  (floppy_base),
  .ide_alt_base (ide_alt_base)
);
